### rtl/buddy_page_allocator_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the buddy page allocator
// Shared helpers for concurrent checks clocked on clk, held off during rst
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bpa_pkg.sv
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Item and result types, command and status codes
// ---------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int TOTAL_PAGES = 4096;
  localparam int NUM_ORDERS  = 11;

  localparam int HEAP_W = 13;
  localparam int PAGE_W = 12;
  localparam int ORD_W  = 4;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_NOFREE  = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [ORD_W-1:0]  order;
    logic [PAGE_W-1:0] page_index;
  } bpa_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] page_index_res;
  } bpa_result_t;

endpackage

`default_nettype wire

### rtl/bpa_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/buddy_page_allocator_core.sv
// ---------------------------------------------------------------------------
// Buddy page allocator core
// Per-order LIFO free lists linked through a page link RAM, XOR pair bits
// in a second RAM, commands for init, allocate and free
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result
// appears on result for a single cycle with done high and must be captured
// then, since the receiver cannot hold it off. Items run one at a time.
// After reset the pair bit RAM is cleared with busy high. Init repeats the
// same clear, then carves blocks into the lists from the top order down.
// Allocate scans the orders upward from the one asked for, pops the head of
// the first list not empty and splits it down level by level. Free checks
// the pair bit at each order and walks the free list to find the buddy and
// climb. Each RAM has a single read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator_core
  import bpa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire bpa_item_t   item,
  output logic             done,
  output bpa_result_t      result,
  input  wire logic        cfg_we,
  input  wire logic [HEAP_W-1:0] cfg_data
);

  localparam int PW  = $clog2(TOTAL_PAGES);
  localparam int LW  = $clog2(TOTAL_PAGES + 1);
  localparam int OW  = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
  localparam int MW  = (PW > NUM_ORDERS) ? PW : NUM_ORDERS;
  localparam int CW  = ((MW > HEAP_W) ? MW : HEAP_W) + 2;
  localparam logic [LW-1:0] EMPTY = LW'(TOTAL_PAGES);
  localparam logic [CW-1:0] TOT   = CW'(TOTAL_PAGES);
  localparam logic [OW-1:0] TOP   = OW'(NUM_ORDERS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CARVE,
    S_A_FIND, S_A_POP, S_A_SPLIT, S_A_FLIP,
    S_F_CHECK, S_F_PAIR, S_F_WALK, S_F_LINK
  } state_t;

  state_t            state;
  logic [HEAP_W-1:0] heap_pages;
  logic [LW-1:0]     heads [NUM_ORDERS];
  logic [OW-1:0]     c;
  logic [OW-1:0]     req;
  logic [PW-1:0]     clr_addr;
  logic              init_pend;
  logic [CW-1:0]     left;
  logic [CW-1:0]     start_pg;
  logic [PW-1:0]     blk;
  logic [PW-1:0]     addr;
  logic [CW-1:0]     f_bud;
  logic [LW-1:0]     cur;
  logic [LW-1:0]     prev;
  logic [LW-1:0]     steps;

  logic          lk_we;
  logic [PW-1:0] lk_waddr;
  logic [LW-1:0] lk_wdata;
  logic [PW-1:0] lk_raddr;
  logic [LW-1:0] lk_rdata;
  logic          pr_we;
  logic [PW-1:0] pr_waddr;
  logic          pr_wdata;
  logic [PW-1:0] pr_raddr;
  logic          pr_rdata;

  // pair bit slot of a block: orders packed one after another
  function automatic logic [CW-1:0] slot_of(logic [OW-1:0] o, logic [CW-1:0] p);
    return (TOT - (TOT >> o)) + ((p >> o) >> 1);
  endfunction

  function automatic logic pair_ok(logic [OW-1:0] o, logic [CW-1:0] p);
    return (o < TOP) && (slot_of(o, p) < TOT);
  endfunction

  // helpers for the order in work
  logic [LW-1:0] head_c;
  logic [CW-1:0] c_bit;
  logic [CW-1:0] a_bud;
  logic [LW-1:0] link_n;
  logic          walk_fail;
  logic          walk_hit;
  logic          pair_set;
  logic [CW-1:0] free_addr;
  logic          free_bad;
  logic          ord_bad;
  logic [CW-1:0] heap_min;

  assign head_c    = heads[c];
  assign c_bit     = CW'(1) << c;
  assign a_bud     = CW'(blk) ^ c_bit;
  assign link_n    = (lk_rdata < EMPTY) ? lk_rdata : EMPTY;
  assign walk_fail = (steps == EMPTY) || (cur >= EMPTY);
  assign walk_hit  = (CW'(cur) == f_bud);
  assign pair_set  = pair_ok(c, CW'(addr)) && pr_rdata;
  assign free_addr = CW'(item.page_index) & ~((CW'(1) << item.order) - CW'(1));
  assign free_bad  = (free_addr >= TOT) || ((TOT - free_addr) < (CW'(1) << item.order));
  assign ord_bad   = 32'(item.order) >= NUM_ORDERS;
  assign heap_min  = (CW'(heap_pages) > TOT) ? TOT : CW'(heap_pages);
  assign busy      = (state != S_IDLE);

  // memory port control
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = '0;
    lk_wdata = head_c;
    lk_raddr = '0;
    pr_we    = 1'b0;
    pr_waddr = '0;
    pr_wdata = 1'b0;
    pr_raddr = '0;
    case (state)
      S_CLEAR: begin
        pr_we    = 1'b1;
        pr_waddr = clr_addr;
      end
      S_CARVE: begin
        if (left >= c_bit) begin
          lk_we    = 1'b1;
          lk_waddr = PW'(start_pg);
          if (pair_ok(c, start_pg)) begin
            pr_we    = 1'b1;
            pr_waddr = PW'(slot_of(c, start_pg));
            pr_wdata = 1'b1;
          end
        end
      end
      S_A_FIND: begin
        lk_raddr = PW'(head_c);
        pr_raddr = PW'(slot_of(c, CW'(head_c)));
      end
      S_A_POP: begin
        if (pair_ok(c, CW'(blk))) begin
          pr_we    = 1'b1;
          pr_waddr = PW'(slot_of(c, CW'(blk)));
          pr_wdata = ~pr_rdata;
        end
      end
      S_A_SPLIT: begin
        if (a_bud < TOT) begin
          lk_we    = 1'b1;
          lk_waddr = PW'(a_bud);
        end
        pr_raddr = PW'(slot_of(c, a_bud));
      end
      S_A_FLIP: begin
        if (pair_ok(c, a_bud)) begin
          pr_we    = 1'b1;
          pr_waddr = PW'(slot_of(c, a_bud));
          pr_wdata = ~pr_rdata;
        end
      end
      S_F_CHECK: begin
        if (c == TOP) begin
          lk_we    = 1'b1;
          lk_waddr = addr;
        end
        pr_raddr = PW'(slot_of(c, CW'(addr)));
      end
      S_F_PAIR: begin
        if (!pair_set) begin
          lk_we    = 1'b1;
          lk_waddr = addr;
          if (pair_ok(c, CW'(addr))) begin
            pr_we    = 1'b1;
            pr_waddr = PW'(slot_of(c, CW'(addr)));
            pr_wdata = ~pr_rdata;
          end
        end
      end
      S_F_WALK: begin
        if (walk_fail) begin
          lk_we    = 1'b1;
          lk_waddr = addr;
        end
        lk_raddr = PW'(cur);
      end
      S_F_LINK: begin
        if (walk_hit) begin
          if (prev != EMPTY) begin
            lk_we    = 1'b1;
            lk_waddr = PW'(prev);
            lk_wdata = link_n;
          end
          pr_we    = 1'b1;
          pr_waddr = PW'(slot_of(c, CW'(addr)));
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer, list heads and result register
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (cfg_we) begin
      heap_pages <= cfg_data;
    end
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      init_pend  <= 1'b0;
      heap_pages <= HEAP_W'(TOTAL_PAGES);
      for (int k = 0; k < NUM_ORDERS; k++) begin
        heads[k] <= EMPTY;
      end
    end else begin
      case (state)
        S_CLEAR: begin
          if (clr_addr == PW'(TOTAL_PAGES - 1)) begin
            state <= init_pend ? S_CARVE : S_IDLE;
          end else begin
            clr_addr <= clr_addr + PW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            case (item.command)
              CMD_INIT: begin
                for (int k = 0; k < NUM_ORDERS; k++) begin
                  heads[k] <= EMPTY;
                end
                clr_addr  <= '0;
                init_pend <= 1'b1;
                left      <= heap_min;
                start_pg  <= '0;
                c         <= TOP;
                state     <= S_CLEAR;
              end
              CMD_ALLOC: begin
                if (ord_bad) begin
                  done   <= 1'b1;
                  result <= '{status: ST_RANGE, page_index_res: '0};
                end else begin
                  c     <= OW'(item.order);
                  req   <= OW'(item.order);
                  state <= S_A_FIND;
                end
              end
              CMD_FREE: begin
                if (ord_bad || free_bad) begin
                  done   <= 1'b1;
                  result <= '{status: ST_RANGE, page_index_res: '0};
                end else begin
                  c     <= OW'(item.order);
                  addr  <= PW'(free_addr);
                  state <= S_F_CHECK;
                end
              end
              default: begin
                done   <= 1'b1;
                result <= '{status: ST_OK, page_index_res: '0};
              end
            endcase
          end
        end
        S_CARVE: begin
          if (left >= c_bit) begin
            heads[c] <= LW'(start_pg);
            left     <= left - c_bit;
            start_pg <= start_pg + c_bit;
          end else if (c == '0) begin
            init_pend <= 1'b0;
            done      <= 1'b1;
            result    <= '{status: ST_OK, page_index_res: '0};
            state     <= S_IDLE;
          end else begin
            c <= c - OW'(1);
          end
        end
        S_A_FIND: begin
          if (head_c < EMPTY) begin
            blk   <= PW'(head_c);
            state <= S_A_POP;
          end else if (c == TOP) begin
            done   <= 1'b1;
            result <= '{status: ST_NOFREE, page_index_res: '0};
            state  <= S_IDLE;
          end else begin
            c <= c + OW'(1);
          end
        end
        S_A_POP: begin
          heads[c] <= link_n;
          if (c == req) begin
            done   <= 1'b1;
            result <= '{status: ST_OK, page_index_res: PAGE_W'(blk)};
            state  <= S_IDLE;
          end else begin
            c     <= c - OW'(1);
            state <= S_A_SPLIT;
          end
        end
        S_A_SPLIT: begin
          if (a_bud < TOT) begin
            heads[c] <= LW'(a_bud);
          end
          state <= S_A_FLIP;
        end
        S_A_FLIP: begin
          if (c == req) begin
            done   <= 1'b1;
            result <= '{status: ST_OK, page_index_res: PAGE_W'(blk)};
            state  <= S_IDLE;
          end else begin
            c     <= c - OW'(1);
            state <= S_A_SPLIT;
          end
        end
        S_F_CHECK: begin
          if (c == TOP) begin
            heads[c] <= LW'(addr);
            done     <= 1'b1;
            result   <= '{status: ST_OK, page_index_res: '0};
            state    <= S_IDLE;
          end else begin
            state <= S_F_PAIR;
          end
        end
        S_F_PAIR: begin
          if (!pair_set) begin
            heads[c] <= LW'(addr);
            done     <= 1'b1;
            result   <= '{status: ST_OK, page_index_res: '0};
            state    <= S_IDLE;
          end else begin
            f_bud <= CW'(addr) ^ c_bit;
            cur   <= head_c;
            prev  <= EMPTY;
            steps <= '0;
            state <= S_F_WALK;
          end
        end
        S_F_WALK: begin
          if (walk_fail) begin
            heads[c] <= LW'(addr);
            done     <= 1'b1;
            result   <= '{status: ST_MISSING, page_index_res: '0};
            state    <= S_IDLE;
          end else begin
            state <= S_F_LINK;
          end
        end
        S_F_LINK: begin
          if (walk_hit) begin
            if (prev == EMPTY) begin
              heads[c] <= link_n;
            end
            if (f_bud < CW'(addr)) begin
              addr <= PW'(f_bud);
            end
            c     <= c + OW'(1);
            state <= S_F_CHECK;
          end else begin
            prev  <= cur;
            cur   <= link_n;
            steps <= steps + LW'(1);
            state <= S_F_WALK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // page link RAM
  bpa_ram #(
    .WIDTH(LW),
    .DEPTH(TOTAL_PAGES)
  ) u_links (
    .clk  (clk),
    .we   (lk_we),
    .waddr(lk_waddr),
    .wdata(lk_wdata),
    .raddr(lk_raddr),
    .rdata(lk_rdata)
  );

  // pair bit RAM
  bpa_ram #(
    .WIDTH(1),
    .DEPTH(TOTAL_PAGES)
  ) u_pairs (
    .clk  (clk),
    .we   (pr_we),
    .waddr(pr_waddr),
    .wdata(pr_wdata),
    .raddr(pr_raddr),
    .rdata(pr_rdata)
  );

endmodule

`default_nettype wire

### rtl/bpa_checker.sv
// ---------------------------------------------------------------------------
// Buddy page allocator port checker
// Watches the command and result ports of the core over time
// ---------------------------------------------------------------------------
`default_nettype none

`include "buddy_page_allocator_core_assert.svh"

module bpa_checker
  import bpa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire bpa_result_t result
);

  // a result only shows once the block is free again
  `BPA_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")

  // an accepted item either starts work or answers at once
  `BPA_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done, "item accepted but dropped")

  // every result stems from an accepted item or from work in flight
  `BPA_ASSERT_NOW(a_done_cause, done, $past(busy) || $past(start), "result without an item")

  // page field is zero whenever the status is an error
  `BPA_ASSERT_NOW(a_res_zero, done && (result.status != ST_OK), result.page_index_res == '0,
                  "page field set on error")

endmodule

bind buddy_page_allocator_core bpa_checker u_chk (.*);

`default_nettype wire

### verif/tb_buddy_page_allocator_core.sv
// ---------------------------------------------------------------------------
// Buddy page allocator core testbench
// Drives init, allocate and free items across several heap sizes and idle
// patterns, predicts every result with a cycle-free model of the free lists
// and pair bits, and checks each result field by field in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

import bpa_pkg::*;

// expected results and the allocator state that produces them
class alloc_scoreboard;
  localparam int NPAGES = 4096;
  localparam int NORDS  = 11;
  localparam int TOP    = NORDS - 1;

  int unsigned heap_size;
  int unsigned heads[NORDS];
  int unsigned links[NPAGES];
  bit          pairs[NPAGES];
  bpa_result_t pending[$];
  int          errors;

  function new();
    heap_size = NPAGES;
    foreach (heads[k]) heads[k] = NPAGES;
    foreach (links[k]) links[k] = 0;
    foreach (pairs[k]) pairs[k] = 1'b0;
    errors = 0;
  endfunction

  function void set_heap(int unsigned v);
    heap_size = v & 13'h1FFF;
  endfunction

  function int unsigned slot(int unsigned ord, int unsigned page);
    return NPAGES - (NPAGES >> ord) + (page >> (ord + 1));
  endfunction

  function void flip(int unsigned ord, int unsigned page);
    int unsigned s;
    if (ord >= TOP) return;
    s = slot(ord, page);
    if (s < NPAGES) pairs[s] ^= 1'b1;
  endfunction

  function bit pair_set(int unsigned ord, int unsigned page);
    int unsigned s;
    if (ord >= TOP) return 1'b0;
    s = slot(ord, page);
    return s < NPAGES && pairs[s];
  endfunction

  function void push(int unsigned ord, int unsigned page);
    if (page >= NPAGES) return;
    links[page] = heads[ord];
    heads[ord] = page;
  endfunction

  function int unsigned link_of(int unsigned page);
    if (page >= NPAGES) return NPAGES;
    return links[page] < NPAGES ? links[page] : NPAGES;
  endfunction

  // remove page from the list of ord, bounded walk
  function bit unlink(int unsigned ord, int unsigned page);
    int unsigned cur;
    int unsigned prev;
    cur = heads[ord];
    prev = NPAGES;
    for (int n = 0; n < NPAGES; n++) begin
      if (cur >= NPAGES) return 1'b0;
      if (cur == page) begin
        if (prev == NPAGES) heads[ord] = link_of(cur);
        else links[prev] = link_of(cur);
        return 1'b1;
      end
      prev = cur;
      cur = link_of(cur);
    end
    return 1'b0;
  endfunction

  // greedy carve from the top order down
  function void carve();
    int unsigned left;
    int unsigned base;
    int unsigned ord;
    int unsigned cnt;
    left = heap_size > NPAGES ? NPAGES : heap_size;
    base = 0;
    foreach (heads[k]) heads[k] = NPAGES;
    foreach (pairs[k]) pairs[k] = 1'b0;
    for (int k = 0; k < NORDS; k++) begin
      ord = TOP - k;
      cnt = left >> ord;
      for (int unsigned i = 0; i < cnt; i++) begin
        push(ord, base + (i << ord));
        flip(ord, base + (i << ord));
      end
      left -= cnt << ord;
      base += cnt << ord;
    end
  endfunction

  function bpa_result_t take(int unsigned ord);
    bpa_result_t r;
    int unsigned c;
    int unsigned blk;
    r = '0;
    c = ord;
    while (c < NORDS && heads[c] >= NPAGES) c++;
    if (c >= NORDS) begin
      r.status = ST_NOFREE;
      return r;
    end
    blk = heads[c];
    heads[c] = link_of(blk);
    flip(c, blk);
    while (c > ord) begin
      c--;
      push(c, blk ^ (1 << c));
      flip(c, blk ^ (1 << c));
    end
    r.status = ST_OK;
    r.page_index_res = blk[PAGE_W-1:0];
    return r;
  endfunction

  function logic [1:0] give_back(int unsigned ord, int unsigned page);
    int unsigned addr;
    int unsigned c;
    int unsigned bud;
    addr = page & ~((1 << ord) - 1);
    c = ord;
    if (addr >= NPAGES || NPAGES - addr < (1 << ord)) return ST_RANGE;
    while (c < TOP) begin
      if (!pair_set(c, addr)) begin
        flip(c, addr);
        push(c, addr);
        return ST_OK;
      end
      bud = addr ^ (1 << c);
      if (!unlink(c, bud)) begin
        push(c, addr);
        return ST_MISSING;
      end
      flip(c, addr);
      if (bud < addr) addr = bud;
      c++;
    end
    push(c, addr);
    return ST_OK;
  endfunction

  // predict the result of an accepted item and queue it
  function bpa_result_t note(bpa_item_t it);
    bpa_result_t r;
    r = '0;
    if (it.command == CMD_INIT) begin
      carve();
    end else if (it.command == CMD_ALLOC || it.command == CMD_FREE) begin
      if (it.order >= NORDS) r.status = ST_RANGE;
      else if (it.command == CMD_ALLOC) r = take(it.order);
      else r.status = give_back(it.order, it.page_index);
    end
    pending.push_back(r);
    return r;
  endfunction

  function void check(bpa_result_t got);
    bpa_result_t want;
    if (pending.size() == 0) begin
      $error("unexpected result status=%0d page=%0d", got.status, got.page_index_res);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.page_index_res !== want.page_index_res) begin
      $error("page_index_res: expected %0d, actual %0d", want.page_index_res,
             got.page_index_res);
      errors++;
    end
  endfunction
endclass

module tb_buddy_page_allocator_core;
  localparam int STALL_LIMIT = 300000;

  typedef struct {
    int unsigned ord;
    int unsigned page;
  } block_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  bpa_item_t   item;
  logic        done;
  bpa_result_t result;
  logic        cfg_we;
  logic [HEAP_W-1:0] cfg_data;

  alloc_scoreboard sb;
  block_t      held[$];
  int          idle_pct;
  int          quiet_cycles;

  buddy_page_allocator_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result capture
  always @(posedge clk) begin
    if (!rst && done) sb.check(result);
  end

  // watchdog on cycles with no item and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL buddy_page_allocator_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item and wait until it is taken, then predict its result
  task automatic send(logic [1:0] cmd, int unsigned ord, int unsigned page);
    bpa_result_t r;
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= '{command: cmd, order: ord[ORD_W-1:0], page_index: page[PAGE_W-1:0]};
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    r = sb.note('{command: cmd, order: ord[ORD_W-1:0], page_index: page[PAGE_W-1:0]});
    if (cmd == CMD_INIT) held.delete();
    if (cmd == CMD_ALLOC && r.status == ST_OK && ord < 11)
      held.push_back('{ord: ord, page: r.page_index_res});
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_heap(int unsigned v);
    drain();
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v[HEAP_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_heap(v);
  endtask

  function automatic int unsigned pick_order();
    return ($urandom_range(9) == 0) ? $urandom_range(10) : $urandom_range(3);
  endfunction

  // one random item: mostly alloc and free of held blocks, some noise
  task automatic random_item();
    int sel;
    int k;
    block_t b;
    sel = $urandom_range(99);
    if (sel < 45) begin
      send(CMD_ALLOC, pick_order(), $urandom_range(4095));
    end else if (sel < 85 && held.size() != 0) begin
      k = $urandom_range(held.size() - 1);
      b = held[k];
      held.delete(k);
      send(CMD_FREE, b.ord, b.page | ($urandom_range(4095) & ((1 << b.ord) - 1)));
    end else if (sel < 89) begin
      send($urandom_range(1) ? CMD_ALLOC : CMD_FREE, $urandom_range(15, 11),
           $urandom_range(4095));
    end else if (sel < 94) begin
      send(CMD_FREE, pick_order(), $urandom_range(4095));
    end else if (sel < 98) begin
      send(CMD_NONE, $urandom_range(15), $urandom_range(4095));
    end else if (sel < 99) begin
      send(CMD_INIT, $urandom_range(15), $urandom_range(4095));
    end else begin
      send(CMD_ALLOC, pick_order(), $urandom_range(4095));
    end
  endtask

  initial begin
    int unsigned heaps[6];
    int          pats[4];
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: frees before init, extremes, bad orders, unused command
    send(CMD_FREE, 0, 0);
    send(CMD_FREE, 0, 4095);
    send(CMD_ALLOC, 0, 0);
    send(CMD_INIT, 15, 4095);
    send(CMD_ALLOC, 10, 0);
    send(CMD_ALLOC, 0, 0);
    send(CMD_ALLOC, 0, 0);
    send(CMD_ALLOC, 11, 0);
    send(CMD_ALLOC, 15, 0);
    send(CMD_FREE, 15, 4095);
    send(CMD_NONE, 15, 4095);
    send(CMD_FREE, 0, 0);
    send(CMD_FREE, 0, 0);                  // double free: buddy missing path
    send(CMD_FREE, 10, 1023);              // unaligned, pushed straight onto the top order list
    send(CMD_FREE, 10, 4095);
    send(CMD_FREE, 0, 4095);
    send(CMD_INIT, 0, 0);
    for (int i = 0; i < 5; i++) send(CMD_ALLOC, 10, 0);
    send(CMD_FREE, 3, 2048);

    heaps = '{0, 1, 8191, 4095, 0, 4096};
    heaps[4] = $urandom_range(2, 4094);
    pats = '{0, 47, 0, 16};
    foreach (heaps[p]) begin
      write_heap(heaps[p]);
      idle_pct = pats[p % 4];
      send(CMD_INIT, $urandom_range(15), $urandom_range(4095));
      for (int i = 0; i < 310; i++) begin
        if (i == 150 && p == 3) drain();   // sender holds until all results are in
        random_item();
      end
    end
    write_heap(4096);

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS buddy_page_allocator_core");
    end else begin
      $display("FAIL buddy_page_allocator_core");
    end
    $finish;
  end
endmodule

`default_nettype wire
